// ===== rtl/core/abp_pkg.sv =====
package abp_pkg;

    localparam int unsigned PixW  = 32;
    localparam int unsigned ChW   = 8;
    localparam int unsigned NumCh = 4;
    localparam int unsigned ProdW = 2 * ChW;
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 8;
    localparam int unsigned AlphaCh  = 3;

    localparam logic [ChW-1:0] ChMax = 8'hFF;

    typedef logic [ChW-1:0]   t_ch;
    typedef logic [ProdW-1:0] t_prod;
    typedef logic [PixW-1:0]  t_pix;

    typedef enum logic [CfgIdxW-1:0] {
        REG_BLEND_MODE   = 2'd0,
        REG_GLOBAL_ALPHA = 2'd1
    } t_cfg_reg;

    typedef enum logic {
        MODE_PREMUL = 1'b0,
        MODE_OPAQUE = 1'b1
    } t_blend_mode;

    typedef enum logic [1:0] {
        OPQ_MIX = 2'd0,
        OPQ_DST = 2'd1,
        OPQ_SRC = 2'd2
    } t_opq_sel;

    typedef struct packed {
        t_blend_mode mode;
        t_ch         alpha;
    } t_cfg;

    // Scaled source, beta and destination for the premultiplied path, plus
    // the finished word for the opaque path.
    typedef struct packed {
        t_blend_mode          mode;
        t_ch [NumCh-1:0]      t;
        t_ch                  beta;
        t_pix                 dst;
        t_pix                 opq;
    } t_mid;

    // Exact floor(x / 255) for x up to 255 * 255.
    function automatic t_ch div255(input t_prod x);
        logic [ProdW:0] s;
        s = {1'b0, x} + (ProdW + 1)'(x[ProdW-1:ChW]) + (ProdW + 1)'(1);
        return s[ProdW-1:ChW];
    endfunction

endpackage

// ===== rtl/core/abp_if.sv =====
interface abp_in_if;
    import abp_pkg::*;
    logic valid;
    logic ready;
    t_pix src_pixel;
    t_pix dst_pixel;
    modport source (output valid, src_pixel, dst_pixel, input ready);
    modport sink   (input valid, src_pixel, dst_pixel, output ready);
endinterface

interface abp_out_if;
    import abp_pkg::*;
    logic valid;
    logic ready;
    t_pix out_pixel;
    modport source (output valid, out_pixel, input ready);
    modport sink   (input valid, out_pixel, output ready);
endinterface

interface abp_cfg_if;
    import abp_pkg::*;
    logic                valid;
    logic                ready;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/argb_pixel_alpha_blend_top.sv =====
// Channel  Dir  Payload                          Handshake
// i_px     in   src_pixel[31:0], dst_pixel[31:0] valid/ready
// o_px     out  out_pixel[31:0]                  valid/ready
// i_cfg    in   index[1:0], data[7:0]            valid/ready (ready always high)
//
// Four register stages: source/destination products, divide by 255,
// beta times destination, composite and saturate into the output register.
// One pixel per clock sustained while o_px is ready. The two 8x8 multiply
// stages are each followed by a divide-by-255 stage. Synchronous active-low
// reset empties the pipeline and sets premultiplied mode with global alpha
// 255. A stall holds each full stage in place.
module argb_pixel_alpha_blend_top
    import abp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    abp_in_if.sink     i_px,
    abp_out_if.source  o_px,
    abp_cfg_if.sink    i_cfg
);

    t_cfg cfg;
    logic mid_valid;
    logic mid_ready;
    t_mid mid;

    abp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    abp_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_px    (i_px),
        .o_valid (mid_valid),
        .i_ready (mid_ready),
        .o_mid   (mid)
    );

    abp_comp u_comp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mid_valid),
        .o_ready (mid_ready),
        .i_mid   (mid),
        .o_px    (o_px)
    );

endmodule

// ===== rtl/core/abp_cfg.sv =====
module abp_cfg
    import abp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    abp_cfg_if.sink   i_cfg,
    output t_cfg      o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode  <= MODE_PREMUL;
            r_cfg.alpha <= ChMax;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                REG_BLEND_MODE:   r_cfg.mode  <= t_blend_mode'(i_cfg.data[0]);
                REG_GLOBAL_ALPHA: r_cfg.alpha <= i_cfg.data[ChW-1:0];
                default: ; // drop writes to unknown registers
            endcase
        end
    end

endmodule

// ===== rtl/core/abp_scale.sv =====
module abp_scale
    import abp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    abp_in_if.sink   i_px,
    output logic     o_valid,
    input  logic     i_ready,
    output t_mid     o_mid
);

    // stage A: products
    logic             r_va;
    t_blend_mode      r_mode_a;
    t_opq_sel         r_sel_a;
    t_pix             r_src_a;
    t_pix             r_dst_a;
    t_prod [NumCh-1:0] r_ps_a;
    t_prod [NumCh-1:0] r_pd_a;
    // stage B: divides
    logic             r_vb;
    t_mid             r_mid_b;

    logic             ready_a;
    logic             ready_b;
    t_ch              ibeta;
    t_opq_sel         n_sel;
    t_prod [NumCh-1:0] n_ps;
    t_prod [NumCh-1:0] n_pd;
    t_mid             n_mid;
    t_pix             mix;

    assign ready_b    = !r_vb || i_ready;
    assign ready_a    = !r_va || ready_b;
    assign i_px.ready = ready_a;
    assign o_valid    = r_vb;
    assign o_mid      = r_mid_b;

    always_comb begin
        ibeta = ChMax - i_cfg.alpha;
        for (int k = 0; k < NumCh; k++) begin
            n_ps[k] = ProdW'(i_px.src_pixel[k*ChW +: ChW]) * ProdW'(i_cfg.alpha);
            n_pd[k] = ProdW'(i_px.dst_pixel[k*ChW +: ChW]) * ProdW'(ibeta);
        end
        if (i_cfg.alpha == '0) begin
            n_sel = OPQ_DST;
        end else if (i_cfg.alpha == ChMax) begin
            n_sel = OPQ_SRC;
        end else begin
            n_sel = OPQ_MIX;
        end
    end

    always_comb begin
        for (int k = 0; k < NumCh; k++) begin
            n_mid.t[k] = div255(r_ps_a[k]);
        end
        n_mid.beta = ChMax - n_mid.t[AlphaCh];
        n_mid.mode = r_mode_a;
        n_mid.dst  = r_dst_a;
        for (int k = 0; k < AlphaCh; k++) begin
            mix[k*ChW +: ChW] = div255(r_ps_a[k] + r_pd_a[k]);
        end
        mix[AlphaCh*ChW +: ChW] = ChMax;
        case (r_sel_a)
            OPQ_DST: n_mid.opq = r_dst_a;
            OPQ_SRC: n_mid.opq = r_src_a;
            default: n_mid.opq = mix;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (ready_a) begin
                r_va <= i_px.valid;
            end
            if (ready_b) begin
                r_vb <= r_va;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a && i_px.valid) begin
            r_mode_a <= i_cfg.mode;
            r_sel_a  <= n_sel;
            r_src_a  <= i_px.src_pixel;
            r_dst_a  <= i_px.dst_pixel;
            r_ps_a   <= n_ps;
            r_pd_a   <= n_pd;
        end
        if (ready_b && r_va) begin
            r_mid_b <= n_mid;
        end
    end

endmodule

// ===== rtl/core/abp_comp.sv =====
module abp_comp
    import abp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_mid       i_mid,
    abp_out_if.source  o_px
);

    // stage C: beta * dst
    logic              r_vc;
    t_blend_mode       r_mode_c;
    t_ch [NumCh-1:0]   r_t_c;
    t_pix              r_opq_c;
    t_prod [NumCh-1:0] r_m_c;
    // stage D: output register
    logic              r_vd;
    t_pix              r_out_d;

    logic              ready_c;
    logic              ready_d;
    t_prod [NumCh-1:0] n_m;
    t_pix              n_out;
    logic [ChW:0]      sum;

    assign ready_d       = !r_vd || o_px.ready;
    assign ready_c       = !r_vc || ready_d;
    assign o_ready       = ready_c;
    assign o_px.valid    = r_vd;
    assign o_px.out_pixel = r_out_d;

    always_comb begin
        for (int k = 0; k < NumCh; k++) begin
            n_m[k] = ProdW'(i_mid.dst[k*ChW +: ChW]) * ProdW'(i_mid.beta);
        end
    end

    always_comb begin
        n_out = r_opq_c;
        sum   = '0;
        if (r_mode_c == MODE_PREMUL) begin
            for (int k = 0; k < NumCh; k++) begin
                sum = (ChW + 1)'(r_t_c[k]) + (ChW + 1)'(div255(r_m_c[k]));
                n_out[k*ChW +: ChW] = sum[ChW] ? ChMax : sum[ChW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            if (ready_c) begin
                r_vc <= i_valid;
            end
            if (ready_d) begin
                r_vd <= r_vc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_c && i_valid) begin
            r_mode_c <= i_mid.mode;
            r_t_c    <= i_mid.t;
            r_opq_c  <= i_mid.opq;
            r_m_c    <= n_m;
        end
        if (ready_d && r_vc) begin
            r_out_d <= n_out;
        end
    end

    // a stalled stage C item must stay put
    a_stage_c_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vc && !ready_d) |=> (r_vc && $stable(r_t_c) && $stable(r_m_c)))
        else $error("stage C item changed under stall");

    // a premultiplied item with zero scaled alpha passes the destination alpha
    a_premul_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ready_d && r_vc && r_mode_c == MODE_PREMUL && r_t_c[AlphaCh] == '0)
        |=> (r_out_d[AlphaCh*ChW +: ChW] == ChW'(r_m_c[AlphaCh] >> ChW)
             || r_out_d[AlphaCh*ChW +: ChW] != ChMax
             || $past(r_m_c[AlphaCh]) == ProdW'(ChMax) * ProdW'(ChMax)))
        else $error("premultiplied alpha saturated unexpectedly");

    // the output register refills only when its item is taken or it is empty
    a_out_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vd && !o_px.ready) |=> (r_vd && $stable(r_out_d)))
        else $error("output item lost under stall");

endmodule
